FILE: rtl/lcdts_pkg.sv
// shared types and constants of the display timing and status block
package lcdts_pkg;

  localparam int DotW  = 11;
  localparam int LineW = 8;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_READ  = 2'd1;
  localparam opcode_t OP_WRITE = 2'd2;

  localparam logic [31:0] ADDR_CONTROL = 32'h0400_0000;
  localparam logic [31:0] ADDR_STATUS  = 32'h0400_0004;
  localparam logic [31:0] ADDR_LINE    = 32'h0400_0006;

  localparam logic [15:0] STATUS_WR_MASK = 16'hfff8;
  localparam logic [15:0] READ_UNKNOWN   = 16'hffff;

  // status word bit positions
  localparam int StVblankFlag = 0;
  localparam int StHblankFlag = 1;
  localparam int StMatchFlag  = 2;
  localparam int StVblankEn   = 3;
  localparam int StHblankEn   = 4;
  localparam int StMatchEn    = 5;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] bus_address;
    logic [15:0] write_value;
  } req_t;

  typedef struct packed {
    logic        in_hblank;
    logic        in_vblank;
    logic        irq_line_match;
    logic        irq_vblank;
    logic        irq_hblank;
    logic [15:0] read_data;
  } res_t;

endpackage

FILE: rtl/lcdts_core.sv
// timing counters, register file and per-item result logic
module lcdts_core #(
  parameter int DOTS_PER_LINE = 1232,
  parameter int HBLANK_START  = 1006,
  parameter int VISIBLE_LINES = 160,
  parameter int TOTAL_LINES   = 228
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  lcdts_pkg::req_t item,
  output lcdts_pkg::res_t result
);

  localparam logic [lcdts_pkg::DotW-1:0]  DotsEnd  = lcdts_pkg::DotW'(DOTS_PER_LINE);
  localparam logic [lcdts_pkg::DotW-1:0]  HblStart = lcdts_pkg::DotW'(HBLANK_START);
  localparam logic [lcdts_pkg::LineW-1:0] VisEnd   = lcdts_pkg::LineW'(VISIBLE_LINES);
  localparam logic [lcdts_pkg::LineW-1:0] LinesEnd = lcdts_pkg::LineW'(TOTAL_LINES);
  localparam logic [lcdts_pkg::LineW-1:0] VblLast  = lcdts_pkg::LineW'(TOTAL_LINES - 2);

  logic [lcdts_pkg::DotW-1:0]  dot_counter, dot_counter_next, dot_inc;
  logic [lcdts_pkg::LineW-1:0] line_counter, line_counter_next, line_inc;
  logic [15:0] control_word, control_word_next;
  logic [15:0] status_word, status_word_next;
  logic [15:0] status_live;
  logic [lcdts_pkg::LineW-1:0] match_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_counter  <= '0;
      line_counter <= '0;
      control_word <= '0;
      status_word  <= '0;
    end else if (advance) begin
      dot_counter  <= dot_counter_next;
      line_counter <= line_counter_next;
      control_word <= control_word_next;
      status_word  <= status_word_next;
    end
  end

  assign match_line = status_word[15:8];
  assign dot_inc    = dot_counter + 1'b1;
  assign line_inc   = line_counter + 1'b1;

  always_comb begin
    status_live = status_word;
    status_live[lcdts_pkg::StVblankFlag] = (line_counter >= VisEnd) && (line_counter <= VblLast);
    status_live[lcdts_pkg::StHblankFlag] = (dot_counter >= HblStart);
    status_live[lcdts_pkg::StMatchFlag]  = (line_counter == match_line);
  end

  always_comb begin
    dot_counter_next  = dot_counter;
    line_counter_next = line_counter;
    control_word_next = control_word;
    status_word_next  = status_word;
    result            = '0;
    unique case (item.opcode)
      lcdts_pkg::OP_TICK: begin
        dot_counter_next = dot_inc;
        if (dot_inc == HblStart) begin
          result.irq_hblank = status_word[lcdts_pkg::StHblankEn];
        end else if (dot_inc == DotsEnd) begin
          dot_counter_next = '0;
          if (line_inc == VisEnd) begin
            result.irq_vblank = status_word[lcdts_pkg::StVblankEn];
            line_counter_next = line_inc;
          end else if (line_inc == LinesEnd) begin
            line_counter_next = '0;
          end else begin
            line_counter_next = line_inc;
          end
          result.irq_line_match = (line_counter_next == match_line) &&
                                  status_word[lcdts_pkg::StMatchEn];
        end
      end
      lcdts_pkg::OP_READ: begin
        priority if (item.bus_address == lcdts_pkg::ADDR_CONTROL) begin
          result.read_data = control_word;
        end else if (item.bus_address == lcdts_pkg::ADDR_STATUS) begin
          result.read_data = status_live;
        end else if (item.bus_address == lcdts_pkg::ADDR_LINE) begin
          result.read_data = 16'(line_counter);
        end else begin
          result.read_data = lcdts_pkg::READ_UNKNOWN;
        end
      end
      lcdts_pkg::OP_WRITE: begin
        if (item.bus_address == lcdts_pkg::ADDR_CONTROL) begin
          control_word_next = item.write_value;
        end else if (item.bus_address == lcdts_pkg::ADDR_STATUS) begin
          status_word_next = item.write_value & lcdts_pkg::STATUS_WR_MASK;
        end
      end
      default: begin
      end
    endcase
    result.in_vblank = (line_counter_next >= VisEnd);
    result.in_hblank = (line_counter_next < VisEnd) && (dot_counter_next >= HblStart);
  end

endmodule

FILE: rtl/lcd_timing_status_irq.sv
// top level of the display timing and status block: input and result registers
// an accepted item passes through the input register and then the result register before its result shows on m_*
// throughput: one item per cycle while m_tready is high; the counter and register update is combinational logic
// while a result waits the input register still takes one more item, then s_tready drops
// back-pressure from m_tready reaches s_tready combinationally, no bubble cycles
// reset: synchronous, active high; clears both valid flags, counters, control and status
module lcd_timing_status_irq #(
  parameter int DOTS_PER_LINE = 1232,
  parameter int HBLANK_START  = 1006,
  parameter int VISIBLE_LINES = 160,
  parameter int TOTAL_LINES   = 228
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // bus_address[31:0], write_value[47:32]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[15:0], irq_hblank[16], irq_vblank[17], irq_line_match[18],
  // in_vblank[19], in_hblank[20], zero fill [23:21]
  output logic [23:0] m_tdata
);

  // input register
  logic            in_valid;
  lcdts_pkg::req_t in_item;

  // result register
  logic            out_valid;
  lcdts_pkg::res_t out_res;
  lcdts_pkg::res_t core_res;

  logic out_free;
  logic advance;

  // the result slot is free when empty or being taken this cycle
  assign out_free = !out_valid || m_tready;
  // an item in the input register is worked on and moves on in the same cycle, once the result slot is free
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode      <= s_tuser;
      in_item.bus_address <= s_tdata[31:0];
      in_item.write_value <= s_tdata[47:32];
    end
  end

  // counters and registers change only when the item moves into the result slot
  lcdts_core #(
    .DOTS_PER_LINE (DOTS_PER_LINE),
    .HBLANK_START  (HBLANK_START),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res};

endmodule

FILE: rtl/lcdts_check.sv
// port-level checker for the display timing and status block, with its bind
module lcdts_check (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // hblank pulse never shares a tick with a line change pulse
  a_irq_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] |-> !m_tdata[17] && !m_tdata[18])
    else $error("hblank pulse together with a line pulse");

  // vblank pulse only while the vblank flag is set
  a_vbl_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17] |-> m_tdata[19])
    else $error("vblank pulse outside vblank");

  // hblank pulse on a visible line shows the live hblank flag
  a_hbl_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[16] && !m_tdata[19] |-> m_tdata[20])
    else $error("hblank pulse without hblank flag");

  // the two live flags exclude each other
  a_blank_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[19] && m_tdata[20]))
    else $error("vblank and hblank flags both set");

endmodule

bind lcd_timing_status_irq lcdts_check u_lcdts_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
